[hw/rtl/keypad_number_entry_display_core_macros.svh]
// ---------------------------------------------------------------------------
// keypad number entry display assertion macros
// clocked property checks on clk, with and without reset gating
// ---------------------------------------------------------------------------
`ifndef KEYPAD_NUMBER_ENTRY_DISPLAY_CORE_MACROS_SVH
`define KEYPAD_NUMBER_ENTRY_DISPLAY_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define KNDE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("knde check failed");

`define KNDE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("knde check failed");

`else

`define KNDE_ASSERT(lbl, prop)
`define KNDE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[hw/rtl/knde_pkg.sv]
// ---------------------------------------------------------------------------
// knde_pkg
// shared types, key codes and constants of the keypad number entry core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package knde_pkg;

	localparam int DIGIT_COUNT_DEF = 8;
	localparam int VALUE_W         = 27;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 4;
	localparam int RECIP_W         = 32;
	localparam int RECIP_SHIFT     = 35;

	localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

	localparam logic [ADDR_W-1:0] ADDR_NONE       = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_SCAN_LIMIT = 4'hB;

	localparam logic OP_START = 1'b0;
	localparam logic OP_KEY   = 1'b1;

	localparam logic [3:0] KEY_ADD2  = 4'd10;
	localparam logic [3:0] KEY_ADD1  = 4'd11;
	localparam logic [3:0] KEY_SUB1  = 4'd12;
	localparam logic [3:0] KEY_SUB2  = 4'd13;
	localparam logic [3:0] KEY_BACK  = 4'd14;
	localparam logic [3:0] KEY_ENTER = 4'd15;

	typedef struct packed {
		logic       operation;
		logic [3:0] key_code;
	} knde_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  reg_addr;
		logic [DATA_W-1:0]  reg_data;
		logic [VALUE_W-1:0] entry_value;
		logic               entry_done;
		logic               last;
	} knde_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDIT_WAIT,
		ST_EDIT,
		ST_DIV,
		ST_DIGIT,
		ST_SCAN,
		ST_DONE
	} knde_state_t;

	typedef struct packed {
		logic start;
		logic close;
		logic take_key;
		logic edit;
		logic digit;
		logic scan;
		logic done;
	} knde_cmd_t;

	typedef struct packed {
		logic entry_open;
		logic work_zero;
		logic pos_last;
		logic out_free;
	} knde_status_t;

	function automatic logic [VALUE_W-1:0] max_value(input int digits);
		logic [VALUE_W-1:0] m;
		int                 i;
		m = VALUE_W'(1);
		for (i = 0; i < digits; i++) begin
			m = VALUE_W'(m * VALUE_W'(10));
		end
		return VALUE_W'(m - VALUE_W'(1));
	endfunction

endpackage

`default_nettype wire

[hw/rtl/knde_ctrl.sv]
// ---------------------------------------------------------------------------
// knde_ctrl
// sequencer for accept, edit, digit extraction and display writes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knde_ctrl import knde_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         key_valid,
	output logic              key_stall,
	input  wire knde_in_t     key,
	input  wire knde_status_t status,
	output knde_cmd_t         cmd
);

	knde_state_t state_q;
	knde_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		key_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				key_stall = 1'b0;
				if (key_valid) begin
					if (key.operation == OP_START) begin
						cmd.start = 1'b1;
					end else if (status.entry_open) begin
						if (key.key_code == KEY_ENTER) begin
							cmd.close  = 1'b1;
							state_next = ST_DONE;
						end else begin
							cmd.take_key = 1'b1;
							state_next   = ST_EDIT_WAIT;
						end
					end
				end
			end
			ST_EDIT_WAIT: begin
				state_next = ST_EDIT;
			end
			ST_EDIT: begin
				cmd.edit   = 1'b1;
				state_next = ST_DIV;
			end
			ST_DIV: begin
				state_next = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (status.out_free) begin
					cmd.digit = 1'b1;
					if (status.work_zero || status.pos_last) begin
						state_next = ST_SCAN;
					end else begin
						state_next = ST_DIV;
					end
				end
			end
			ST_SCAN: begin
				if (status.out_free) begin
					cmd.scan   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.done   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/knde_dpath.sv]
// ---------------------------------------------------------------------------
// knde_dpath
// entry value, divide-by-ten unit, digit counter and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knde_dpath import knde_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire knde_in_t  key,
	input  wire knde_cmd_t cmd,
	output knde_status_t   status,
	output logic           disp_valid,
	input  wire logic      disp_stall,
	output knde_out_t      disp
);

	localparam int PROD_W = VALUE_W + RECIP_W;
	localparam int WIDE_W = VALUE_W + 4;
	localparam logic [VALUE_W-1:0] TOP = max_value(DIGIT_COUNT);
	localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(DIGIT_COUNT);

	logic [VALUE_W-1:0] entry_q;
	logic               open_q;
	logic [3:0]         key_q;
	logic [VALUE_W-1:0] work_q;
	logic [VALUE_W-1:0] quo_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [DATA_W-1:0]  scan_q;
	logic               out_valid_q;
	knde_out_t          out_q;

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quo_ten;
	logic [VALUE_W-1:0] rem_full;
	logic [WIDE_W-1:0]  ext;
	logic [WIDE_W-1:0]  wide;
	logic [VALUE_W-1:0] new_value;
	logic               push;
	knde_out_t          out_next;

	// reciprocal multiply for divide by ten
	assign prod     = PROD_W'(work_q) * PROD_W'(RECIP_TEN);
	assign quo_ten  = VALUE_W'((quo_q << 3) + (quo_q << 1));
	assign rem_full = VALUE_W'(work_q - quo_ten);

	always_comb begin
		ext = WIDE_W'(entry_q);
		unique case (key_q)
			KEY_BACK: wide = WIDE_W'(quo_q);
			KEY_ADD2: wide = WIDE_W'(ext + WIDE_W'(2));
			KEY_ADD1: wide = WIDE_W'(ext + WIDE_W'(1));
			KEY_SUB1: wide = (ext < WIDE_W'(1)) ? '0 : WIDE_W'(ext - WIDE_W'(1));
			KEY_SUB2: wide = (ext < WIDE_W'(2)) ? '0 : WIDE_W'(ext - WIDE_W'(2));
			default:  wide = WIDE_W'((ext << 3) + (ext << 1) + WIDE_W'(key_q));
		endcase
		new_value = (wide > WIDE_W'(TOP)) ? TOP : wide[VALUE_W-1:0];
	end

	assign status.entry_open = open_q;
	assign status.work_zero  = (work_q == '0);
	assign status.pos_last   = (pos_q == POS_LAST);
	assign status.out_free   = !out_valid_q || !disp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			open_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				entry_q <= '0;
				open_q  <= 1'b1;
			end else if (cmd.edit) begin
				entry_q <= new_value;
			end
			if (cmd.close) begin
				open_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		quo_q <= VALUE_W'(prod >> RECIP_SHIFT);
		if (cmd.take_key) begin
			key_q  <= key.key_code;
			work_q <= entry_q;
		end else if (cmd.edit) begin
			work_q <= new_value;
			pos_q  <= ADDR_W'(1);
		end else if (cmd.digit) begin
			if (work_q == '0) begin
				scan_q <= (pos_q == ADDR_W'(1)) ? '0 : DATA_W'(pos_q - ADDR_W'(2));
			end else begin
				scan_q <= DATA_W'(pos_q - ADDR_W'(1));
				pos_q  <= ADDR_W'(pos_q + ADDR_W'(1));
				work_q <= quo_q;
			end
		end
	end

	assign push = cmd.digit || cmd.scan || cmd.done;

	always_comb begin
		out_next             = '0;
		out_next.entry_value = entry_q;
		priority if (cmd.done) begin
			out_next.reg_addr   = ADDR_NONE;
			out_next.entry_done = 1'b1;
			out_next.last       = 1'b1;
		end else if (cmd.scan) begin
			out_next.reg_addr = ADDR_SCAN_LIMIT;
			out_next.reg_data = scan_q;
			out_next.last     = 1'b1;
		end else begin
			out_next.reg_addr = pos_q;
			out_next.reg_data = rem_full[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!disp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= out_next;
		end
	end

	assign disp_valid = out_valid_q;
	assign disp       = out_q;

endmodule

`default_nettype wire

[hw/rtl/keypad_number_entry_display_core.sv]
// ---------------------------------------------------------------------------
// keypad_number_entry_display_core
// keypad number entry with display driver register writes
// ---------------------------------------------------------------------------
// A start request clears the value and opens entry; key requests edit the
// value while entry is open and produce the digit writes (units first, one
// trailing zero write when not all digits are used) followed by a scan-limit
// write, the last one marked. Enter closes entry and returns one result with
// entry_done set. One request is worked at a time. A start or an ignored key
// is handled in the idle state; enter's result is registered in the done state.
// An edit passes the wait and edit states, a divide and a digit state per digit
// write, then the scan state; digits come from the shared divide-by-ten
// reciprocal multiplier. Output stall holds the digit, scan and done states.
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_number_entry_display_core_macros.svh"

module keypad_number_entry_display_core import knde_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     key_valid,
	output logic          key_stall,
	input  wire knde_in_t key,
	output logic          disp_valid,
	input  wire logic     disp_stall,
	output knde_out_t     disp
);

	knde_cmd_t    cmd;
	knde_status_t status;

	knde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key       (key),
		.status    (status),
		.cmd       (cmd)
	);

	knde_dpath #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key),
		.cmd        (cmd),
		.status     (status),
		.disp_valid (disp_valid),
		.disp_stall (disp_stall),
		.disp       (disp)
	);

	`KNDE_ASSERT(a_one_push, $onehot0({cmd.digit, cmd.scan, cmd.done}))
	`KNDE_ASSERT(a_push_free, (cmd.digit || cmd.scan || cmd.done) |-> status.out_free)
	`KNDE_ASSERT(a_done_last, (disp_valid && disp.entry_done) |-> disp.last)
	`KNDE_ASSERT(a_close, cmd.close |=> !status.entry_open)

endmodule

`default_nettype wire

[tb/keypad_number_entry_display_checker.sv]
// ---------------------------------------------------------------------------
// keypad_number_entry_display_checker
// watches the keypad request and display write channels of the entry core,
// predicts the display writes of every accepted request and compares each
// accepted write field by field against the oldest predicted one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_number_entry_display_checker import knde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      key_valid,
	input  logic      key_stall,
	input  knde_in_t  key,
	input  logic      disp_valid,
	input  logic      disp_stall,
	input  knde_out_t disp,
	output int        mismatches,
	output int        outstanding
);

	localparam logic [VALUE_W-1:0] VALUE_TOP = VALUE_W'(99999999);

	knde_out_t          display_writes[$];
	logic [VALUE_W-1:0] entry_num;
	logic               entry_open;
	int                 err_count;

	function automatic void push_write(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data, input logic [VALUE_W-1:0] value,
			input logic done, input logic fin);
		knde_out_t w;
		w.reg_addr    = addr;
		w.reg_data    = data;
		w.entry_value = value;
		w.entry_done  = done;
		w.last        = fin;
		display_writes.push_back(w);
	endfunction

	// digit writes from the units upward, then the scan limit
	function automatic void queue_display(input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] rest;
		logic [ADDR_W-1:0]  pos;
		bit                 stop;
		int                 i;
		rest = value;
		pos  = ADDR_W'(1);
		stop = 1'b0;
		if (value == '0) begin
			push_write(ADDR_W'(1), '0, value, 1'b0, 1'b0);
			push_write(ADDR_SCAN_LIMIT, '0, value, 1'b0, 1'b1);
		end else begin
			for (i = 0; i < DIGIT_COUNT_DEF && !stop; i++) begin
				push_write(pos, DATA_W'(rest % 10), value, 1'b0, 1'b0);
				if (rest == '0) begin
					stop = 1'b1;
				end else begin
					pos  = pos + ADDR_W'(1);
					rest = VALUE_W'(rest / 10);
				end
			end
			push_write(ADDR_SCAN_LIMIT, DATA_W'(pos - ADDR_W'(2)), value, 1'b0, 1'b1);
		end
	endfunction

	function automatic void predict_request(input knde_in_t req);
		logic [31:0] v;
		if (req.operation == OP_START) begin
			entry_num  = '0;
			entry_open = 1'b1;
		end else if (entry_open) begin
			if (req.key_code == KEY_ENTER) begin
				entry_open = 1'b0;
				push_write(ADDR_NONE, '0, entry_num, 1'b1, 1'b1);
			end else begin
				v = 32'(entry_num);
				case (req.key_code)
					KEY_BACK: v = v / 10;
					KEY_ADD2: v = v + 2;
					KEY_ADD1: v = v + 1;
					KEY_SUB1: v = (v >= 1) ? v - 1 : 0;
					KEY_SUB2: v = (v >= 2) ? v - 2 : 0;
					default:  v = v * 10 + 32'(req.key_code);
				endcase
				if (v > 32'(VALUE_TOP)) begin
					v = 32'(VALUE_TOP);
				end
				entry_num = VALUE_W'(v);
				queue_display(entry_num);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		knde_out_t exp_w;
		if (!arst_n) begin
			entry_num  = '0;
			entry_open = 1'b0;
			err_count  = 0;
			display_writes.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (disp_valid && !disp_stall) begin
				if (display_writes.size() == 0) begin
					err_count++;
					if (err_count <= 10) begin
						$display("%0t unexpected display write: addr=%0d data=%0d value=%0d done=%0b last=%0b",
							$realtime, disp.reg_addr, disp.reg_data, disp.entry_value,
							disp.entry_done, disp.last);
					end
				end else begin
					exp_w = display_writes.pop_front();
					if (disp.reg_addr !== exp_w.reg_addr || disp.reg_data !== exp_w.reg_data ||
							disp.entry_value !== exp_w.entry_value ||
							disp.entry_done !== exp_w.entry_done || disp.last !== exp_w.last) begin
						err_count++;
						if (err_count <= 10) begin
							$display("%0t display write mismatch: expected addr=%0d data=%0d value=%0d done=%0b last=%0b",
								$realtime, exp_w.reg_addr, exp_w.reg_data, exp_w.entry_value,
								exp_w.entry_done, exp_w.last);
							$display("%0t                          actual addr=%0d data=%0d value=%0d done=%0b last=%0b",
								$realtime, disp.reg_addr, disp.reg_data, disp.entry_value,
								disp.entry_done, disp.last);
						end
					end
				end
			end
			if (key_valid && !key_stall) begin
				predict_request(key);
			end
			mismatches  <= err_count;
			outstanding <= display_writes.size();
		end
	end

endmodule

[tb/keypad_number_entry_display_core_tb.sv]
// ---------------------------------------------------------------------------
// keypad_number_entry_display_core_tb
// drives start and key requests into the entry core with random gaps and
// output stalls; a directed pass covers the bounds and every function key, then
// random entry sequences mixed with noise; the checker judges every write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_number_entry_display_core_tb;
	import knde_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      key_valid;
	logic      key_stall;
	knde_in_t  key;
	logic      disp_valid;
	logic      disp_stall;
	knde_out_t disp;
	int        mismatches;
	int        outstanding;
	bit        open_tb;
	bit        steady;
	int        live_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	keypad_number_entry_display_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key        (key),
		.disp_valid (disp_valid),
		.disp_stall (disp_stall),
		.disp       (disp)
	);

	keypad_number_entry_display_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.key         (key),
		.disp_valid  (disp_valid),
		.disp_stall  (disp_stall),
		.disp        (disp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic int pick_gap();
		int n;
		n = $urandom_range(0, 99);
		if (steady || n < 65) begin
			return 0;
		end else if (n < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [3:0] pick_edit_key();
		int n;
		n = $urandom_range(0, 99);
		if (n < 60) begin
			return 4'($urandom_range(0, 9));
		end else if (n < 70) begin
			return KEY_BACK;
		end
		return 4'($urandom_range(KEY_ADD2, KEY_SUB2));
	endfunction

	task automatic send_request(input logic op, input logic [3:0] code);
		knde_in_t req;
		int       gap;
		req.operation = op;
		req.key_code  = code;
		gap = pick_gap();
		if (gap > 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_valid <= 1'b1;
		key       <= req;
		@(posedge clk);
		while (key_stall) @(posedge clk);
		if (op == OP_START) begin
			open_tb = 1'b1;
			live_count++;
		end else if (open_tb) begin
			live_count++;
			if (code == KEY_ENTER) begin
				open_tb = 1'b0;
			end
		end
	endtask

	// hold off requests until every predicted write has come out
	task automatic wait_drained();
		key_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// output stall: free stretches, short stalls and a few long ones
	initial begin
		int n;
		forever begin
			n = $urandom_range(0, 99);
			if (n < 50) begin
				disp_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else if (n < 92) begin
				disp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				disp_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int r;
		int len;
		int k;
		int base;
		bit digits_only;
		arst_n     <= 1'b0;
		key_valid  <= 1'b0;
		key        <= '0;
		open_tb    = 1'b0;
		steady     = 1'b0;
		live_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: closed keys, bounds, every function key
		send_request(OP_KEY, 4'd7);
		send_request(OP_KEY, KEY_ENTER);
		send_request(OP_START, KEY_ENTER);
		send_request(OP_KEY, 4'd0);
		send_request(OP_KEY, KEY_SUB1);
		send_request(OP_KEY, KEY_SUB2);
		send_request(OP_KEY, KEY_ADD2);
		send_request(OP_KEY, KEY_ADD1);
		send_request(OP_KEY, KEY_SUB2);
		send_request(OP_KEY, KEY_BACK);
		repeat (9) send_request(OP_KEY, 4'd9);
		send_request(OP_KEY, KEY_ADD2);
		send_request(OP_KEY, KEY_BACK);
		send_request(OP_KEY, KEY_SUB1);
		send_request(OP_KEY, KEY_ENTER);
		send_request(OP_START, 4'd0);
		send_request(OP_KEY, 4'd1);
		send_request(OP_START, 4'd5);
		send_request(OP_KEY, KEY_ENTER);
		wait_drained();

		// random entry sequences with some noise and broken sequences
		base = live_count;
		while (live_count - base < 480) begin
			r           = $urandom_range(0, 99);
			steady      = ($urandom_range(0, 4) == 0);
			digits_only = ($urandom_range(0, 5) == 0);
			if (r < 80) begin
				send_request(OP_START, 4'($urandom));
				len = digits_only ? $urandom_range(8, 11) : $urandom_range(1, 12);
				for (k = 0; k < len; k++) begin
					send_request(OP_KEY, digits_only ? 4'($urandom_range(0, 9)) :
						pick_edit_key());
				end
				if ($urandom_range(0, 9) != 0) begin
					send_request(OP_KEY, KEY_ENTER);
				end
			end else begin
				repeat ($urandom_range(1, 4)) send_request(1'($urandom), 4'($urandom));
			end
			if ($urandom_range(0, 15) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (2 * DIGIT_COUNT_DEF + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
